// File: hdl/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg - block ring with drop accounting, shared definitions
// Widths, command and status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package brd_pkg;

	localparam int RING_DEPTH = 16;
	localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FILL_W     = 5;
	localparam int LEN_W      = 20;
	localparam int VLEN_W     = 21;
	localparam int CNT_W      = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [LEN_W-1:0]  MAX_BLOCK_RESET  = LEN_W'(262144);
	localparam logic [FILL_W-1:0] RING_SLOTS_RESET = FILL_W'(16);

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_STOP = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_DROPPED = 3'd1,
		ST_REFUSED = 3'd2,
		ST_POPPED  = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_BLOCK  = 2'd0,
		REG_RING_SLOTS = 2'd1
	} reg_idx_t;

endpackage

// File: hdl/brd_if.sv
// ----------------------------------------------------------------------------
// brd_if - channel interfaces of the block ring
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface brd_req_if
	import brd_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [1:0]               cmd;
	logic signed [VLEN_W-1:0] push_length;

	modport source (output valid, cmd, push_length, input ready);
	modport sink   (input valid, cmd, push_length, output ready);
endinterface

interface brd_rsp_if
	import brd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [LEN_W-1:0]  block_length;
	logic              was_truncated;
	logic [CNT_W-1:0]  start_sample;
	logic [FILL_W-1:0] occupancy;
	logic              stopped;
	logic [CNT_W-1:0]  received_count;
	logic [CNT_W-1:0]  dropped_count;
	logic [CNT_W-1:0]  truncated_count;
	logic [CNT_W-1:0]  byte_total;
	logic [FILL_W-1:0] peak_occupancy;

	modport source (output valid, status, block_length, was_truncated, start_sample,
		occupancy, stopped, received_count, dropped_count, truncated_count, byte_total,
		peak_occupancy, input ready);
	modport sink (input valid, status, block_length, was_truncated, start_sample,
		occupancy, stopped, received_count, dropped_count, truncated_count, byte_total,
		peak_occupancy, output ready);
endinterface

interface brd_cfg_if
	import brd_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/brd_slot_index.sv
// ----------------------------------------------------------------------------
// brd_slot_index - ring slot index tracker
// Keeps a transaction count modulo every ring size at once; selects by size.
// ----------------------------------------------------------------------------
module brd_slot_index
	import brd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [FILL_W-1:0] cap,
	output logic [SLOT_W-1:0] idx
);

	// res_q[k] holds the count modulo k+1
	logic [SLOT_W-1:0] res_q [RING_DEPTH];
	logic [FILL_W-1:0] cap_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RING_DEPTH; k++) begin
				res_q[k] <= '0;
			end
		end else if (step) begin
			for (int k = 0; k < RING_DEPTH; k++) begin
				if (res_q[k] == SLOT_W'(k)) begin
					res_q[k] <= '0;
				end else begin
					res_q[k] <= res_q[k] + 1'b1;
				end
			end
		end
	end

	assign cap_m1 = cap - 1'b1;
	assign idx    = res_q[cap_m1[SLOT_W-1:0]];

endmodule

// File: hdl/block_ring_with_drop_accounting_core.sv
// ----------------------------------------------------------------------------
// block_ring_with_drop_accounting_core - block descriptor ring, top level
// Stores block descriptors pushed by a receive producer, hands them to a
// consumer in order, and keeps drop, truncation and byte statistics.
// ----------------------------------------------------------------------------
//
//  channel | role   | payload                                   | moves
//  --------+--------+-------------------------------------------+-------------
//  req     | sink   | cmd, push_length                          | one command
//  rsp     | source | status, length, sample index, statistics  | one result
//  cfg     | sink   | index, data                               | register wr
//
// Each request transaction gives exactly one response transaction. A request
// is held in an input register, worked by short combinational logic and the
// result lands in the response register: one transaction per cycle sustained
// while rsp takes each response. The response register frees as it is
// taken, so a stall on rsp backs up only as far as the input register.
// Reset clears all pointers, counters and flags; slot contents are not reset.
// cfg is always ready; write it only while no transaction is in flight.
// ----------------------------------------------------------------------------
module block_ring_with_drop_accounting_core
	import brd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	brd_req_if.sink   req,
	brd_rsp_if.source rsp,
	brd_cfg_if.sink   cfg
);

	// ---------------- configuration registers ----------------
	logic [LEN_W-1:0]  max_block_q;
	logic [FILL_W-1:0] ring_slots_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_block_q  <= MAX_BLOCK_RESET;
			ring_slots_q <= RING_SLOTS_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MAX_BLOCK:  max_block_q  <= cfg.data[LEN_W-1:0];
				REG_RING_SLOTS: ring_slots_q <= cfg.data[FILL_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective ring size: zero acts as one, oversize clamps to the depth
	logic [FILL_W-1:0] cap;
	always_comb begin
		if (ring_slots_q == '0) begin
			cap = FILL_W'(1);
		end else if (ring_slots_q > FILL_W'(RING_DEPTH)) begin
			cap = FILL_W'(RING_DEPTH);
		end else begin
			cap = ring_slots_q;
		end
	end

	// ---------------- input register ----------------
	logic                     valid_s1;
	logic [1:0]               cmd_s1;
	logic signed [VLEN_W-1:0] vlen_s1;
	logic                     rsp_valid_q;
	logic                     adv;

	// Advance the input stage whenever the response register is free or
	// being emptied in this cycle
	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1  <= req.cmd;
			vlen_s1 <= req.push_length;
		end
	end

	// ---------------- ring state ----------------
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] max_fill_q;
	logic              stop_q;
	logic [CNT_W-1:0]  next_sample_q;
	logic [CNT_W-1:0]  accepted_q;
	logic [CNT_W-1:0]  dropped_q;
	logic [CNT_W-1:0]  clipped_q;
	logic [CNT_W-1:0]  bytes_q;

	logic [LEN_W-1:0]  slot_len_q    [RING_DEPTH];
	logic [CNT_W-1:0]  slot_sample_q [RING_DEPTH];

	logic [SLOT_W-1:0] wr_idx;
	logic [SLOT_W-1:0] rd_idx;

	// ---------------- single-pass command logic ----------------
	status_t           status_c;
	logic [LEN_W-1:0]  blen_c;
	logic              trunc_c;
	logic [CNT_W-1:0]  first_c;
	logic              do_push;
	logic              do_pop;
	logic              do_drop;
	logic              set_stop;

	logic [LEN_W-1:0]  raw_len;
	logic              clip;
	logic [LEN_W-1:0]  len_clip;
	logic [LEN_W-1:0]  len_even;

	// Negative lengths count as zero; clip to the block size, then round to even
	assign raw_len  = vlen_s1[VLEN_W-1] ? '0 : vlen_s1[LEN_W-1:0];
	assign clip     = raw_len > max_block_q;
	assign len_clip = clip ? max_block_q : raw_len;
	assign len_even = {len_clip[LEN_W-1:1], 1'b0};

	always_comb begin
		status_c = ST_STORED;
		blen_c   = '0;
		trunc_c  = 1'b0;
		first_c  = '0;
		do_push  = 1'b0;
		do_pop   = 1'b0;
		do_drop  = 1'b0;
		set_stop = 1'b0;
		case (cmd_s1)
			CMD_PUSH: begin
				if (stop_q) begin
					status_c = ST_REFUSED;
				end else if (fill_q >= cap) begin
					status_c = ST_DROPPED;
					do_drop  = 1'b1;
				end else begin
					status_c = ST_STORED;
					do_push  = 1'b1;
					blen_c   = len_even;
					trunc_c  = clip;
					first_c  = next_sample_q;
				end
			end
			CMD_POP: begin
				if (fill_q == '0) begin
					status_c = ST_EMPTY;
				end else begin
					status_c = ST_POPPED;
					do_pop   = 1'b1;
					blen_c   = slot_len_q[rd_idx];
					first_c  = slot_sample_q[rd_idx];
				end
			end
			default: begin
				// stop request; the unused code acts the same
				status_c = ST_REFUSED;
				set_stop = 1'b1;
			end
		endcase
	end

	// Next state values, shared by the state and the response register
	logic [FILL_W-1:0] fill_inc;
	logic [FILL_W-1:0] fill_nx;
	logic [FILL_W-1:0] max_fill_nx;
	logic              stop_nx;
	logic [CNT_W-1:0]  accepted_nx;
	logic [CNT_W-1:0]  dropped_nx;
	logic [CNT_W-1:0]  clipped_nx;
	logic [CNT_W-1:0]  bytes_nx;

	assign fill_inc = fill_q + 1'b1;

	always_comb begin
		fill_nx     = fill_q;
		max_fill_nx = max_fill_q;
		accepted_nx = accepted_q;
		clipped_nx  = clipped_q;
		bytes_nx    = bytes_q;
		dropped_nx  = do_drop ? dropped_q + 1'b1 : dropped_q;
		stop_nx     = stop_q | set_stop;
		if (do_push) begin
			fill_nx     = fill_inc;
			accepted_nx = accepted_q + 1'b1;
			bytes_nx    = bytes_q + CNT_W'(len_even);
			if (clip) begin
				clipped_nx = clipped_q + 1'b1;
			end
			if (fill_inc > max_fill_q) begin
				max_fill_nx = fill_inc;
			end
		end else if (do_pop) begin
			fill_nx = fill_q - 1'b1;
		end
	end

	// Slot pointers: count modulo the current ring size
	brd_slot_index u_wr_index (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv && do_push),
		.cap    (cap),
		.idx    (wr_idx)
	);

	brd_slot_index u_rd_index (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv && do_pop),
		.cap    (cap),
		.idx    (rd_idx)
	);

	// Hold counters and flags; advance them only as the transaction moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			max_fill_q    <= '0;
			stop_q        <= 1'b0;
			next_sample_q <= '0;
			accepted_q    <= '0;
			dropped_q     <= '0;
			clipped_q     <= '0;
			bytes_q       <= '0;
		end else if (adv) begin
			fill_q     <= fill_nx;
			max_fill_q <= max_fill_nx;
			stop_q     <= stop_nx;
			accepted_q <= accepted_nx;
			dropped_q  <= dropped_nx;
			clipped_q  <= clipped_nx;
			bytes_q    <= bytes_nx;
			if (do_push) begin
				// sample counter advances by half the byte length
				next_sample_q <= next_sample_q + CNT_W'(len_even[LEN_W-1:1]);
			end
		end
	end

	// Slot store: written on a stored push only, never cleared
	always_ff @(posedge clk) begin
		if (adv && do_push) begin
			slot_len_q[wr_idx]    <= len_even;
			slot_sample_q[wr_idx] <= next_sample_q;
		end
	end

	// ---------------- response register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	logic [2:0]        status_s2;
	logic [LEN_W-1:0]  blen_s2;
	logic              trunc_s2;
	logic [CNT_W-1:0]  first_s2;
	logic [FILL_W-1:0] occ_s2;
	logic              stopped_s2;
	logic [CNT_W-1:0]  received_s2;
	logic [CNT_W-1:0]  dropped_s2;
	logic [CNT_W-1:0]  truncated_s2;
	logic [CNT_W-1:0]  byte_total_s2;
	logic [FILL_W-1:0] peak_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2     <= status_c;
			blen_s2       <= blen_c;
			trunc_s2      <= trunc_c;
			first_s2      <= first_c;
			occ_s2        <= fill_nx;
			stopped_s2    <= stop_nx;
			received_s2   <= accepted_nx;
			dropped_s2    <= dropped_nx;
			truncated_s2  <= clipped_nx;
			byte_total_s2 <= bytes_nx;
			peak_s2       <= max_fill_nx;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_s2;
	assign rsp.block_length    = blen_s2;
	assign rsp.was_truncated   = trunc_s2;
	assign rsp.start_sample    = first_s2;
	assign rsp.occupancy       = occ_s2;
	assign rsp.stopped         = stopped_s2;
	assign rsp.received_count  = received_s2;
	assign rsp.dropped_count   = dropped_s2;
	assign rsp.truncated_count = truncated_s2;
	assign rsp.byte_total      = byte_total_s2;
	assign rsp.peak_occupancy  = peak_s2;

endmodule
